// ===== sv/sas_pkg.sv =====
// Package for the shifting array store: sizes, codes, payload structs and
// the command and status groups between controller and datapath. No dependencies.
`default_nettype none

package sas_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 11;
  localparam int CAP_W  = 11;
  localparam int DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  // Register index as decoded from the word address on the APB port.
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_DELETE = 2'd3
  } action_t;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_BOUNDS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    action_t                   action;
    logic [CNT_W-1:0]          position;
    logic signed [DATA_W-1:0]  word_in;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  read_data;
    logic [1:0]                status;
    logic [CNT_W-1:0]          occupancy;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic latch_status;
    logic read_pos;
    logic write_word;
    logic init_up;
    logic init_down;
    logic shift_up;
    logic shift_down;
    logic count_inc;
    logic count_dec;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t action;
    logic    refuse;
    logic    at_end;
    logic    del_last;
    logic    up_last;
    logic    down_last;
    logic    out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/sas_ctrl.sv =====
// Controller state machine for the shifting array store.
// Depends on sas_pkg for the command and status structs.
`default_nettype none

module sas_ctrl
  import sas_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SHIFT_UP,
    S_SHIFT_DOWN,
    S_DRAIN_UP,
    S_DRAIN_DOWN,
    S_PUT,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.latch_status = 1'b1;
        if (stat.refuse) begin
          state_next = S_RESULT;
        end else begin
          case (stat.action)
            ACT_READ: begin
              cmd.read_pos = 1'b1;
              state_next   = S_RESULT;
            end
            ACT_WRITE: begin
              cmd.write_word = 1'b1;
              state_next     = S_RESULT;
            end
            ACT_INSERT: begin
              if (stat.at_end) begin
                state_next = S_PUT;
              end else begin
                cmd.init_up = 1'b1;
                state_next  = S_SHIFT_UP;
              end
            end
            ACT_DELETE: begin
              if (stat.del_last) begin
                cmd.count_dec = 1'b1;
                state_next    = S_RESULT;
              end else begin
                cmd.init_down = 1'b1;
                state_next    = S_SHIFT_DOWN;
              end
            end
            default: state_next = S_RESULT;
          endcase
        end
      end
      S_SHIFT_UP: begin
        cmd.shift_up = 1'b1;
        if (stat.up_last) begin
          state_next = S_DRAIN_UP;
        end
      end
      S_DRAIN_UP: begin
        // The last moved word is written back here; the new word follows.
        state_next = S_PUT;
      end
      S_PUT: begin
        cmd.write_word = 1'b1;
        cmd.count_inc  = 1'b1;
        state_next     = S_RESULT;
      end
      S_SHIFT_DOWN: begin
        cmd.shift_down = 1'b1;
        if (stat.down_last) begin
          state_next = S_DRAIN_DOWN;
        end
      end
      S_DRAIN_DOWN: begin
        cmd.count_dec = 1'b1;
        state_next    = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sas_datapath.sv =====
// Datapath of the shifting array store: entry memory, count, shift pointer,
// capacity register, status checks and the result register. Uses sas_pkg.
`default_nettype none

module sas_datapath
  import sas_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire req_t              req_data,
  output rsp_t                   rsp_data,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  action_t                  act;
  logic [CNT_W-1:0]         pos;
  logic signed [DATA_W-1:0] word;
  logic [CNT_W-1:0]         count;
  logic [CAP_W-1:0]         cap;
  logic [CNT_W-1:0]         ptr;
  logic                     pend_valid;
  logic [ADDR_W-1:0]        pend_addr;
  logic signed [DATA_W-1:0] rd_q;
  logic [1:0]               status;

  logic [CNT_W-1:0]         eff_cap;
  logic [CNT_W-1:0]         ptr_dec;
  logic [CNT_W-1:0]         ptr_inc;
  logic [CNT_W-1:0]         pos_inc;
  logic                     bounds;
  logic                     full;
  logic [1:0]               status_next;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_wa;
  logic signed [DATA_W-1:0] mem_wd;
  logic                     mem_re;
  logic [ADDR_W-1:0]        mem_ra;
  logic                     cfg_we;

  assign eff_cap = (cap > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap;
  assign ptr_dec = ptr - CNT_W'(1);
  assign ptr_inc = ptr + CNT_W'(1);
  assign pos_inc = pos + CNT_W'(1);

  assign bounds = (act == ACT_INSERT) ? (pos > count) : (pos >= count);
  assign full   = (act == ACT_INSERT) && (count >= eff_cap);
  assign status_next = bounds ? ST_BOUNDS : (full ? ST_FULL : ST_DONE);

  assign stat.action    = act;
  assign stat.refuse    = bounds | full;
  assign stat.at_end    = (pos == count);
  assign stat.del_last  = (pos_inc == count);
  assign stat.up_last   = (ptr_dec == pos);
  assign stat.down_last = (ptr_inc == count);
  assign stat.out_free  = !rsp_valid | rsp_ready;

  // A pending move always wins the write port; the controller never asks for
  // a word write in the same cycle.
  assign mem_we = pend_valid | cmd.write_word;
  assign mem_wa = pend_valid ? pend_addr : pos[ADDR_W-1:0];
  assign mem_wd = pend_valid ? rd_q : word;
  assign mem_re = cmd.read_pos | cmd.shift_up | cmd.shift_down;

  always_comb begin
    if (cmd.read_pos) begin
      mem_ra = pos[ADDR_W-1:0];
    end else if (cmd.shift_up) begin
      mem_ra = ptr_dec[ADDR_W-1:0];
    end else begin
      mem_ra = ptr[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  assign cfg_we = psel & penable & pwrite & (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap} : 32'd0;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act  <= req_data.action;
      pos  <= req_data.position;
      word <= req_data.word_in;
    end
    if (cmd.latch_status) begin
      status <= status_next;
    end
    if (cmd.init_up) begin
      ptr <= count;
    end else if (cmd.init_down) begin
      ptr <= pos_inc;
    end else if (cmd.shift_up) begin
      ptr <= ptr_dec;
    end else if (cmd.shift_down) begin
      ptr <= ptr_inc;
    end
    if (cmd.shift_up) begin
      pend_addr <= ptr[ADDR_W-1:0];
    end else if (cmd.shift_down) begin
      pend_addr <= ptr_dec[ADDR_W-1:0];
    end
    if (cmd.load_out) begin
      rsp_data.status    <= status;
      rsp_data.occupancy <= count;
      if (act == ACT_READ) begin
        rsp_data.read_data <= (status == ST_BOUNDS) ? -DATA_W'(1) : rd_q;
      end else begin
        rsp_data.read_data <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      cap        <= CAP_RESET;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= pwdata[CAP_W-1:0];
      end
      if (cmd.count_inc) begin
        count <= count + CNT_W'(1);
      end else if (cmd.count_dec) begin
        count <= count - CNT_W'(1);
      end
      pend_valid <= cmd.shift_up | cmd.shift_down;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/shifting_array_store.sv =====
// Shifting array store top level: one transaction at a time. Reads, writes, refused
// requests and deletes of the last entry go straight to the result; an append at the
// count only adds the write of the new word. Other inserts first shift the entries from
// the position to the end up by one, other deletes the entries above the position down
// by one; each shift cycle moves one entry through the 1R1W entry memory. Synchronous
// active-high reset empties the list, sets capacity to 1024.
`default_nettype none

module shifting_array_store
  import sas_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire req_t        req_data,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output rsp_t             rsp_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // The controller sequences each transaction: it decides the outcome from the
  // bounds and capacity checks, then walks the shift pointer one entry per cycle.
  // The datapath holds the memory, the count and the result register, so a
  // finished result can wait for the consumer while the next request is taken.
  // Entry contents are not cleared by reset; only positions below the count are
  // ever read.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The configuration port never stalls.
  assign pready = 1'b1;

  sas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sas_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .rsp_data  (rsp_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

// ===== test/list_store_checker.sv =====
// Checker for the shifting array store: watches the request, response and APB
// ports, predicts every response from its own copy of the list and compares it.
// Depends on sas_pkg for the payload types, sizes and codes.
module list_store_checker
  import sas_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_ready,
  input  req_t             req_data,
  input  logic             rsp_valid,
  input  logic             rsp_ready,
  input  rsp_t             rsp_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  input  logic [31:0]      prdata,
  input  logic             pready,
  output logic [CNT_W-1:0] list_count,
  output int               results_owed,
  output int               fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [DATA_W-1:0] shadow_words [DEPTH];
  logic [CNT_W-1:0]         shadow_count;
  logic [CAP_W-1:0]         shadow_cap;
  rsp_t                     owed_rsp [$];
  int                       errs;

  initial begin
    shadow_count = '0;
    shadow_cap = CAP_RESET;
    errs = 0;
    list_count = '0;
    results_owed = 0;
    fail_count = 0;
  end

  // Applies one request to the shadow list and returns the response it owes.
  function automatic rsp_t apply_list_op(req_t r);
    rsp_t o;
    int   p;
    int   cnt;
    int   lim;
    int   i;
    o.read_data = '0;
    o.status = ST_DONE;
    p = int'(r.position);
    cnt = int'(shadow_count);
    // Capacity values above the memory size saturate to the memory size.
    lim = (int'(shadow_cap) > DEPTH) ? DEPTH : int'(shadow_cap);
    case (r.action)
      ACT_READ: begin
        if (p >= cnt) begin
          o.status = ST_BOUNDS;
          o.read_data = -1;
        end else begin
          o.read_data = shadow_words[p];
        end
      end
      ACT_WRITE: begin
        if (p >= cnt) o.status = ST_BOUNDS;
        else shadow_words[p] = r.word_in;
      end
      ACT_INSERT: begin
        if (p > cnt) begin
          o.status = ST_BOUNDS;
        end else if (cnt >= lim) begin
          o.status = ST_FULL;
        end else begin
          for (i = cnt; i > p; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[p] = r.word_in;
          shadow_count = shadow_count + 1'b1;
        end
      end
      ACT_DELETE: begin
        if (p >= cnt) begin
          o.status = ST_BOUNDS;
        end else begin
          for (i = p; i < cnt - 1; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count = shadow_count - 1'b1;
        end
      end
      default: begin
      end
    endcase
    o.occupancy = shadow_count;
    return o;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    rsp_t got;
    logic bad;
    if (rst) begin
      owed_rsp.delete();
      shadow_count = '0;
      shadow_cap = CAP_RESET;
    end else begin
      // Responses first: a response never belongs to a request accepted at the same edge.
      if (rsp_valid && rsp_ready) begin
        got = rsp_data;
        if (owed_rsp.size() == 0) begin
          $display("%0t: response with none expected: read_data %h status %0d occupancy %0d",
                   $time, got.read_data, got.status, got.occupancy);
          errs++;
        end else begin
          want = owed_rsp.pop_front();
          bad = 1'b0;
          if (got.read_data !== want.read_data) begin
            $display("%0t: read_data expected %h, actual %h",
                     $time, want.read_data, got.read_data);
            bad = 1'b1;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
            bad = 1'b1;
          end
          if (got.occupancy !== want.occupancy) begin
            $display("%0t: occupancy expected %0d, actual %0d",
                     $time, want.occupancy, got.occupancy);
            bad = 1'b1;
          end
          if (bad) errs++;
        end
      end
      if (req_valid && req_ready) owed_rsp.push_back(apply_list_op(req_data));
      if (psel && penable && pready && paddr[2] == REG_CAPACITY) begin
        if (pwrite) begin
          shadow_cap = pwdata[CAP_W-1:0];
        end else if (prdata !== 32'(shadow_cap)) begin
          $display("%0t: capacity_limit read expected %h, actual %h",
                   $time, 32'(shadow_cap), prdata);
          errs++;
        end
      end
    end
    list_count <= shadow_count;
    results_owed <= owed_rsp.size();
    fail_count <= errs;
  end

endmodule

// ===== test/testbench.sv =====
// Top of the shifting array store testbench: clock, reset, request and APB
// stimulus, response back-pressure and the verdict. Depends on sas_pkg, the
// shifting_array_store RTL and the list_store_checker module.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sas_pkg::*;

  localparam int         RESET_CYCLES    = 6;
  localparam int         RSP_HOLD_CYCLES = 300;
  localparam int         SETTLE_CYCLES   = 6;
  localparam int         TAIL_CYCLES     = 12;
  localparam int         FILL_LEN        = 120;
  localparam longint     LIMIT_CYCLES    = 64'd15_000_000;
  localparam logic [2:0] CAP_ADDR        = {REG_CAPACITY, 2'b00};
  // Word address with no register behind it; writes there must be ignored.
  localparam logic [2:0] SPARE_ADDR      = {~REG_CAPACITY, 2'b00};

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  req_t             req_data = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_t             rsp_data;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  logic [CNT_W-1:0] list_count;
  int               results_owed;
  int               fail_count;

  // Idling switches and the long receiver hold-off handshake between processes.
  bit               sender_idle = 1'b1;
  bit               receiver_idle = 1'b1;
  int               hold_requests = 0;
  int               holds_done = 0;
  longint           cycle_count = 0;

  shifting_array_store DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  list_store_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req_data     (req_data),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp_data     (rsp_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .list_count   (list_count),
    .results_owed (results_owed),
    .fail_count   (fail_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog. The bound covers every transaction taking a full-depth shift plus
  // the longest sender gap and receiver stall, several times over.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Response back-pressure. A pending hold-off request drops ready for a long,
  // counted stretch; otherwise ready drops in short random bursts while idling
  // is enabled, and stays high once it is disabled.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        rsp_ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
        holds_done++;
        rsp_ready <= 1'b1;
      end else if (receiver_idle && $urandom_range(0, 7) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Moves to the next edge, sometimes leaving the request channel idle for a
  // short burst first. The checker's list count is current once this returns.
  task automatic wait_slot();
    @(posedge clk);
    if (sender_idle && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // Offers one transaction and holds it until the block takes it. Valid drops at
  // the accepting edge; the next offer always starts at a later edge.
  task automatic push_req(input req_t r);
    req_valid <= 1'b1;
    req_data <= r;
    do @(posedge clk); while (!req_ready);
    req_valid <= 1'b0;
  endtask

  task automatic issue(input action_t a, input int p, input logic [31:0] w);
    req_t r;
    wait_slot();
    r.action = a;
    r.position = p[CNT_W-1:0];
    r.word_in = w;
    push_req(r);
  endtask

  // The outstanding count is registered behind the checker's queue, hence the edge first.
  task automatic wait_drained();
    do @(posedge clk); while (results_owed != 0);
  endtask

  // Capacity is only changed with the block idle; the read-back is checked.
  task automatic set_capacity(input logic [31:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_access(1'b1, CAP_ADDR, v);
    apb_access(1'b0, CAP_ADDR, '0);
  endtask

  // Data words lean toward the sign and all-ones extremes.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Builds a transaction for a list holding c entries. Inserts are favored
  // below the target length and deletes above it, so the list wanders around
  // the target. Most positions are in range; the rest sit on the boundary,
  // just past it, or anywhere in the field. A few transactions are pure noise.
  function automatic req_t pick_req(int c, int target);
    req_t r;
    int   roll;
    int   ins_weight;
    r.word_in = pick_word();
    if ($urandom_range(0, 19) == 0) begin
      r.action = action_t'($urandom_range(0, 3));
      r.position = CNT_W'($urandom_range(0, 2047));
      return r;
    end
    ins_weight = (c < target) ? 45 : 15;
    roll = $urandom_range(0, 99);
    if (roll < 20) r.action = ACT_READ;
    else if (roll < 35) r.action = ACT_WRITE;
    else if (roll < 35 + ins_weight) r.action = ACT_INSERT;
    else r.action = ACT_DELETE;
    roll = $urandom_range(0, 99);
    if (roll < 6) r.position = CNT_W'(c);
    else if (roll < 10) r.position = CNT_W'(c + 1);
    else if (roll < 13) r.position = CNT_W'($urandom_range(0, 2047));
    else if (r.action == ACT_INSERT) r.position = CNT_W'($urandom_range(0, c));
    else r.position = (c > 0) ? CNT_W'($urandom_range(0, c - 1)) : '0;
    return r;
  endfunction

  task automatic run_mix(input int n, input int target);
    req_t r;
    repeat (n) begin
      wait_slot();
      r = pick_req(int'(list_count), target);
      push_req(r);
    end
  endtask

  initial begin : stimulus
    req_t r;
    int   c;
    int   p;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // The capacity register must read back its reset value.
    apb_access(1'b0, CAP_ADDR, '0);

    // Directed part. Every access to an empty list is refused, including an
    // insert past the end and one with every position bit set.
    issue(ACT_READ, 0, 32'h0);
    issue(ACT_WRITE, 0, 32'h1234_5678);
    issue(ACT_DELETE, 0, 32'h0);
    issue(ACT_INSERT, 1, 32'h1);
    issue(ACT_INSERT, 2047, 32'h2);
    // Build a four-entry list: inserts below the count shift, an insert at the count appends.
    issue(ACT_INSERT, 0, 32'h7FFF_FFFF);
    issue(ACT_INSERT, 0, 32'h8000_0000);
    issue(ACT_INSERT, 2, 32'hFFFF_FFFF);
    issue(ACT_INSERT, 1, 32'h0000_0000);
    issue(ACT_READ, 0, 32'h0);
    issue(ACT_READ, 3, 32'h0);
    // Read and write exactly at the count are out of bounds.
    issue(ACT_READ, 4, 32'h0);
    issue(ACT_WRITE, 3, 32'h5555_AAAA);
    issue(ACT_WRITE, 4, 32'hAAAA_5555);
    issue(ACT_READ, 3, 32'h0);
    issue(ACT_READ, 1024, 32'h0);
    // Delete from the middle, then the last entry, then past the end.
    issue(ACT_DELETE, 1, 32'h0);
    issue(ACT_DELETE, 2, 32'h0);
    issue(ACT_DELETE, 3, 32'h0);
    issue(ACT_READ, 1, 32'h0);
    issue(ACT_DELETE, 0, 32'h0);
    issue(ACT_DELETE, 0, 32'h0);
    issue(ACT_READ, 0, 32'h0);

    // Random part at the reset capacity. Midway the receiver holds off for a
    // long stretch while requests keep coming, so the block backs up; later the
    // sender stops until every outstanding response has arrived.
    run_mix(40, 40);
    hold_requests++;
    run_mix(30, 40);
    wait_drained();
    run_mix(30, 40);

    // Capacity lowered below the current length: entries stay, inserts are
    // refused as full until deletes bring the length under the limit.
    set_capacity(32'd12);
    run_mix(50, 20);

    // A write to an address without a register must leave capacity untouched;
    // the read-back that follows is checked against the previous value.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_access(1'b1, SPARE_ADDR, 32'd5);
    apb_access(1'b0, CAP_ADDR, '0);

    // Zero capacity: no insert can succeed.
    set_capacity(32'd0);
    run_mix(25, 10);
    set_capacity(32'd1);
    run_mix(25, 4);

    // All capacity bits set: saturates to the memory depth.
    set_capacity(32'h0000_07FF);
    run_mix(60, 30);

    // Grow the list up to a capacity of FILL_LEN, mostly by appending; an
    // occasional insert lands at a random place and shifts the tail.
    set_capacity(32'(FILL_LEN));
    while (list_count < CNT_W'(FILL_LEN)) begin
      wait_slot();
      c = int'(list_count);
      p = ($urandom_range(0, 15) == 0) ? $urandom_range(0, c) : c;
      r.action = ACT_INSERT;
      r.position = CNT_W'(p);
      r.word_in = pick_word();
      push_req(r);
    end
    // At capacity: inserts at the end and front are full, one past the end is
    // out of bounds, and the top entry is read, written and read back. A front
    // delete and a front insert walk the whole list.
    issue(ACT_INSERT, FILL_LEN, 32'h3);
    issue(ACT_INSERT, 0, 32'h4);
    issue(ACT_INSERT, FILL_LEN + 1, 32'h5);
    issue(ACT_READ, FILL_LEN - 1, 32'h0);
    issue(ACT_WRITE, FILL_LEN - 1, 32'h8000_0001);
    issue(ACT_READ, FILL_LEN - 1, 32'h0);
    issue(ACT_DELETE, 0, 32'h0);
    issue(ACT_INSERT, 0, 32'h7FFF_FFFE);
    issue(ACT_READ, 0, 32'h0);
    issue(ACT_DELETE, FILL_LEN - 1, 32'h0);
    // Drain, mostly from the end so the shifts stay short.
    while (list_count != 0) begin
      wait_slot();
      c = int'(list_count);
      if (c == 0) p = 0;
      else if ($urandom_range(0, 15) == 0) p = $urandom_range(0, c - 1);
      else p = c - 1;
      r.action = ACT_DELETE;
      r.position = CNT_W'(p);
      r.word_in = pick_word();
      push_req(r);
    end

    // Back to the reset capacity; the final stretch runs without idling.
    set_capacity(32'd1024);
    run_mix(30, 30);
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    run_mix(30, 30);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
